/* rtl/stsgb_pkg.sv */
// ----------------------------------------------------------------------------
// stsgb_pkg
// shared constants, types and helpers of the sensor-tuned spike generator bank
// ----------------------------------------------------------------------------
package stsgb_pkg;

  localparam int SOURCES   = 32;
  localparam int SRC_AW    = $clog2(SOURCES);
  localparam int CNT_W     = $clog2(SOURCES + 1);
  localparam int TBL_DEPTH = 512;
  localparam int TBL_AW    = $clog2(TBL_DEPTH);
  localparam int FRAC_BITS = 15;

  localparam logic signed [31:0] ONE_FIX  = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [49:0] HALF_FIX = 50'sd1 <<< (FRAC_BITS - 1);

  // dividend magnitude of the rescale division: |countdown| << FRAC_BITS
  localparam int DIV_W   = 32 + FRAC_BITS;
  localparam int DIV_CW  = $clog2(DIV_W);

  localparam logic [1:0] KIND_TICK   = 2'd0;
  localparam logic [1:0] KIND_SENSOR = 2'd1;
  localparam logic [1:0] KIND_TABLE  = 2'd2;
  localparam logic [1:0] KIND_SOURCE = 2'd3;

  localparam logic [2:0] REG_HAS_KEY      = 3'd0;
  localparam logic [2:0] REG_ROUTING_KEY  = 3'd1;
  localparam logic [2:0] REG_SENSOR_OFF   = 3'd2;
  localparam logic [2:0] REG_SENSOR_RANGE = 3'd3;
  localparam logic [2:0] REG_INPUT_SHIFT  = 3'd4;
  localparam logic [2:0] REG_LUT_SCALE    = 3'd5;
  localparam logic [2:0] REG_PERIOD_FLOOR = 3'd6;
  localparam logic [2:0] REG_SOURCE_COUNT = 3'd7;

  typedef struct packed {
    logic [15:0]        src_tag;
    logic [30:0]        mean_period;
    logic signed [31:0] countdown;
  } src_entry_t;

  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) r = v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    else r = v[31:0];
    return r;
  endfunction

endpackage

/* rtl/sensor_tuned_spike_generator_bank_unit.sv */
// ----------------------------------------------------------------------------
// sensor_tuned_spike_generator_bank_unit
// bank of periodic spike sources whose periods follow a sensor value
// ----------------------------------------------------------------------------
// One transaction at a time is taken. Table and source loads write their
// memory in the cycle they are accepted. A tick walks the active sources from
// the source memory, waiting on the output register when a spike is due, then
// sends the end-of-tick marker. A sensor sample forms the table index by a
// multiply and reads the table, then rescales each source with a nonzero period
// by the one-bit-per-cycle restoring divider that forms countdown / old period
// (47 steps); sources with a zero period only take the new period.
module sensor_tuned_spike_generator_bank_unit
  import stsgb_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_addr,
  input  logic [31:0]   cfg_wdata,
  input  logic          in_tvalid,
  output logic          in_tready,
  // sample[31:0], slot[40:32], period[71:41], countdown[103:72], source_id[119:104]
  input  logic [119:0]  in_tdata,
  // kind[1:0]
  input  logic [1:0]    in_tuser,
  output logic          out_tvalid,
  input  logic          out_tready,
  // packet_key[31:0], spike_id[47:32]
  output logic [47:0]   out_tdata,
  // sent_to_fabric[0], is_spike[1]
  output logic [1:0]    out_tuser,
  output logic          out_tlast
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_T_RD  = 4'd1;
  localparam logic [3:0] S_T_EV  = 4'd2;
  localparam logic [3:0] S_MARK  = 4'd3;
  localparam logic [3:0] S_S_MUL = 4'd4;
  localparam logic [3:0] S_S_IDX = 4'd5;
  localparam logic [3:0] S_S_TBL = 4'd6;
  localparam logic [3:0] S_S_RD  = 4'd7;
  localparam logic [3:0] S_S_LD  = 4'd8;
  localparam logic [3:0] S_S_DIV = 4'd9;
  localparam logic [3:0] S_S_SAT = 4'd10;
  localparam logic [3:0] S_S_MPY = 4'd11;
  localparam logic [3:0] S_S_WB  = 4'd12;

  // configuration
  logic               has_key_r;
  logic [31:0]        routing_key_r;
  logic signed [15:0] sensor_off_r;
  logic [15:0]        clamp_hi_r;
  logic [4:0]         samp_shift_r;
  logic [30:0]        lut_scale_r;
  logic [30:0]        period_floor_r;
  logic [5:0]         source_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      has_key_r      <= 1'b0;
      routing_key_r  <= '0;
      sensor_off_r   <= -16'sd256;
      clamp_hi_r     <= 16'd1700;
      samp_shift_r   <= '0;
      lut_scale_r    <= 31'd9865;
      period_floor_r <= '0;
      source_count_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_HAS_KEY:      has_key_r      <= cfg_wdata[0];
        REG_ROUTING_KEY:  routing_key_r  <= cfg_wdata;
        REG_SENSOR_OFF:   sensor_off_r   <= cfg_wdata[15:0];
        REG_SENSOR_RANGE: clamp_hi_r     <= cfg_wdata[15:0];
        REG_INPUT_SHIFT:  samp_shift_r   <= cfg_wdata[4:0];
        REG_LUT_SCALE:    lut_scale_r    <= cfg_wdata[30:0];
        REG_PERIOD_FLOOR: period_floor_r <= cfg_wdata[30:0];
        REG_SOURCE_COUNT: source_count_r <= cfg_wdata[5:0];
        default: ;
      endcase
    end
  end

  // input fields
  logic [1:0]         in_kind;
  logic [31:0]        in_sample;
  logic [8:0]         in_slot;
  logic [30:0]        in_period;
  logic signed [31:0] in_countdown;
  logic [15:0]        in_source_id;

  assign in_kind      = in_tuser;
  assign in_sample    = in_tdata[31:0];
  assign in_slot      = in_tdata[40:32];
  assign in_period    = in_tdata[71:41];
  assign in_countdown = in_tdata[103:72];
  assign in_source_id = in_tdata[119:104];

  logic [3:0]         state_r, state_nxt;
  logic               first_done_r, first_done_nxt;
  logic [SRC_AW-1:0]  idx_r, idx_nxt;
  logic signed [17:0] val_r, val_nxt;
  logic signed [49:0] lprod_r, lprod_nxt;
  logic               use_floor_r, use_floor_nxt;
  logic [TBL_AW-1:0]  tbl_addr_r, tbl_addr_nxt;
  logic [30:0]        fresh_r, fresh_nxt;
  src_entry_t         cur_r, cur_nxt;
  logic               neg_r, neg_nxt;
  logic [DIV_W-1:0]   q_r, q_nxt;
  logic [30:0]        rem_r, rem_nxt;
  logic [DIV_CW-1:0]  dcnt_r, dcnt_nxt;
  logic signed [31:0] ratio_r, ratio_nxt;
  logic signed [63:0] mprod_r, mprod_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [47:0]        out_data_r, out_data_nxt;
  logic [1:0]         out_user_r, out_user_nxt;
  logic               out_last_r, out_last_nxt;

  // memories
  logic [30:0]        tbl_mem [TBL_DEPTH];
  logic [30:0]        tbl_rd_r;
  logic               tbl_we;
  logic [TBL_AW-1:0]  tbl_wa;
  logic [30:0]        tbl_wd;

  src_entry_t         src_mem [SOURCES];
  src_entry_t         src_rd_r;
  logic               src_we;
  logic [SRC_AW-1:0]  src_wa;
  src_entry_t         src_wd;

  always_ff @(posedge clk) begin
    if (tbl_we) tbl_mem[tbl_wa] <= tbl_wd;
    tbl_rd_r <= tbl_mem[tbl_addr_r];
  end

  always_ff @(posedge clk) begin
    if (src_we) src_mem[src_wa] <= src_wd;
    src_rd_r <= src_mem[idx_r];
  end

  logic [5:0] n_act;
  logic       idx_is_last;
  logic       out_free;
  logic       accept;

  assign n_act       = (source_count_r > 6'(SOURCES)) ? 6'(SOURCES) : source_count_r;
  assign idx_is_last = ({{(6 - SRC_AW){1'b0}}, idx_r} == n_act - 6'd1);
  assign out_free    = !out_valid_r || out_tready;
  assign in_tready   = (state_r == S_IDLE);
  assign accept      = in_tvalid && in_tready;

  // datapath temporaries
  logic [31:0]        shifted;
  logic signed [33:0] sval;
  logic signed [49:0] lsum;
  logic signed [31:0] tick_c1, tick_c2;
  logic [31:0]        cd_mag;
  logic [31:0]        trial;
  logic signed [63:0] floor_v;
  logic signed [31:0] next_cd;

  always_comb begin
    state_nxt      = state_r;
    first_done_nxt = first_done_r;
    idx_nxt        = idx_r;
    val_nxt        = val_r;
    lprod_nxt      = lprod_r;
    use_floor_nxt  = use_floor_r;
    tbl_addr_nxt   = tbl_addr_r;
    fresh_nxt      = fresh_r;
    cur_nxt        = cur_r;
    neg_nxt        = neg_r;
    q_nxt          = q_r;
    rem_nxt        = rem_r;
    dcnt_nxt       = dcnt_r;
    ratio_nxt      = ratio_r;
    mprod_nxt      = mprod_r;
    out_valid_nxt  = out_tready ? 1'b0 : out_valid_r;
    out_data_nxt   = out_data_r;
    out_user_nxt   = out_user_r;
    out_last_nxt   = out_last_r;
    tbl_we = 1'b0;
    tbl_wa = in_slot[TBL_AW-1:0];
    tbl_wd = in_period;
    src_we = 1'b0;
    src_wa = idx_r;
    src_wd = cur_r;

    shifted = in_sample >> samp_shift_r;
    sval    = $signed({{2{shifted[31]}}, shifted}) -
              $signed({{18{sensor_off_r[15]}}, sensor_off_r});
    lsum    = lprod_r + HALF_FIX;
    tick_c1 = sat33($signed({src_rd_r.countdown[31], src_rd_r.countdown}) +
                    $signed({2'b00, src_rd_r.mean_period}));
    tick_c2 = '0;
    cd_mag  = src_rd_r.countdown[31] ? 32'(-src_rd_r.countdown)
                                     : 32'(src_rd_r.countdown);
    trial   = {rem_r, q_r[DIV_W-1]};
    floor_v = mprod_r >>> FRAC_BITS;
    if (floor_v[63:31] != {33{floor_v[31]}})
      next_cd = floor_v[63] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    else
      next_cd = floor_v[31:0];

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_kind)
            KIND_TICK: begin
              first_done_nxt = 1'b1;
              idx_nxt        = '0;
              state_nxt      = (first_done_r && n_act != 6'd0) ? S_T_RD : S_MARK;
            end
            KIND_SENSOR: begin
              if (sval > $signed({18'b0, clamp_hi_r}))
                sval = $signed({18'b0, clamp_hi_r});
              // below this bound any nonzero scale already gives a negative sum
              if (sval < -34'sd131072) sval = -34'sd131072;
              val_nxt   = sval[17:0];
              // source 0 is read while the index is formed
              idx_nxt   = '0;
              state_nxt = S_S_MUL;
            end
            KIND_TABLE: begin
              tbl_we = ({23'b0, in_slot} < 32'(TBL_DEPTH));
            end
            KIND_SOURCE: begin
              src_we = ({23'b0, in_slot} < 32'(SOURCES));
              src_wa = in_slot[SRC_AW-1:0];
              src_wd = '{src_tag: in_source_id, mean_period: in_period,
                         countdown: in_countdown};
            end
            default: ;
          endcase
        end
      end

      S_T_RD: state_nxt = S_T_EV;

      S_T_EV: begin
        if (src_rd_r.mean_period == '0) begin
          if (idx_is_last) state_nxt = S_MARK;
          else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_T_RD;
          end
        end else if (src_rd_r.countdown <= 0 && !out_free) begin
          state_nxt = S_T_EV;
        end else begin
          if (src_rd_r.countdown <= 0) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = {src_rd_r.src_tag,
                             has_key_r ? (routing_key_r | {16'b0, src_rd_r.src_tag})
                                       : 32'b0};
            out_user_nxt  = {1'b1, has_key_r};
            out_last_nxt  = 1'b0;
            tick_c2 = sat33($signed({tick_c1[31], tick_c1}) - $signed({ONE_FIX[31], ONE_FIX}));
          end else begin
            tick_c2 = sat33($signed({src_rd_r.countdown[31], src_rd_r.countdown}) -
                            $signed({ONE_FIX[31], ONE_FIX}));
          end
          src_we = 1'b1;
          src_wd = src_rd_r;
          src_wd.countdown = tick_c2;
          if (idx_is_last) state_nxt = S_MARK;
          else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_T_RD;
          end
        end
      end

      S_MARK: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_user_nxt  = '0;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      S_S_MUL: begin
        lprod_nxt = $signed({{32{val_r[17]}}, val_r}) * $signed({19'b0, lut_scale_r});
        state_nxt = S_S_IDX;
      end

      S_S_IDX: begin
        use_floor_nxt = lsum[49] || (lsum[48:FRAC_BITS + TBL_AW] != '0);
        tbl_addr_nxt  = lsum[FRAC_BITS + TBL_AW - 1:FRAC_BITS];
        state_nxt     = S_S_TBL;
      end

      // table data for the registered address appears in the next cycle
      S_S_TBL: state_nxt = S_S_RD;

      S_S_RD: begin
        fresh_nxt = use_floor_r ? period_floor_r : tbl_rd_r;
        idx_nxt   = '0;
        state_nxt = (n_act == 6'd0) ? S_IDLE : S_S_LD;
      end

      S_S_LD: begin
        cur_nxt = src_rd_r;
        if (src_rd_r.mean_period == '0) begin
          src_we = 1'b1;
          src_wd = src_rd_r;
          src_wd.mean_period = fresh_r;
          if (idx_is_last) state_nxt = S_IDLE;
          else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_S_SAT;
          end
        end else begin
          neg_nxt   = src_rd_r.countdown[31];
          q_nxt     = {cd_mag, {FRAC_BITS{1'b0}}};
          rem_nxt   = '0;
          dcnt_nxt  = '0;
          state_nxt = S_S_DIV;
        end
      end

      S_S_DIV: begin
        if (trial >= {1'b0, cur_r.mean_period}) begin
          rem_nxt = 31'(trial - {1'b0, cur_r.mean_period});
          q_nxt   = {q_r[DIV_W-2:0], 1'b1};
        end else begin
          rem_nxt = trial[30:0];
          q_nxt   = {q_r[DIV_W-2:0], 1'b0};
        end
        dcnt_nxt = dcnt_r + 1'b1;
        if (dcnt_r == DIV_CW'(DIV_W - 1)) state_nxt = S_S_SAT;
      end

      // saturate the quotient, or wait for the next source's read
      S_S_SAT: begin
        if (cur_r.mean_period == '0) begin
          state_nxt = S_S_LD;
        end else begin
          if (neg_r)
            ratio_nxt = (q_r > DIV_W'(64'h8000_0000)) ? 32'sh8000_0000 : 32'(-q_r[31:0]);
          else
            ratio_nxt = (q_r > DIV_W'(64'h7fff_ffff)) ? 32'sh7fff_ffff : q_r[31:0];
          state_nxt = S_S_MPY;
        end
      end

      S_S_MPY: begin
        mprod_nxt = $signed({{32{ratio_r[31]}}, ratio_r}) * $signed({33'b0, fresh_r});
        state_nxt = S_S_WB;
      end

      S_S_WB: begin
        src_we = 1'b1;
        src_wd = cur_r;
        src_wd.mean_period = fresh_r;
        if (next_cd > 0) src_wd.countdown = next_cd;
        cur_nxt.mean_period = '0;
        if (idx_is_last) state_nxt = S_IDLE;
        else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_S_SAT;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      first_done_r <= 1'b0;
      out_valid_r  <= 1'b0;
      idx_r        <= '0;
      dcnt_r       <= '0;
    end else begin
      state_r      <= state_nxt;
      first_done_r <= first_done_nxt;
      out_valid_r  <= out_valid_nxt;
      idx_r        <= idx_nxt;
      dcnt_r       <= dcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r       <= val_nxt;
    lprod_r     <= lprod_nxt;
    use_floor_r <= use_floor_nxt;
    tbl_addr_r  <= tbl_addr_nxt;
    fresh_r     <= fresh_nxt;
    cur_r       <= cur_nxt;
    neg_r       <= neg_nxt;
    q_r         <= q_nxt;
    rem_r       <= rem_nxt;
    ratio_r     <= ratio_nxt;
    mprod_r     <= mprod_nxt;
    out_data_r  <= out_data_nxt;
    out_user_r  <= out_user_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule

/* rtl/stsgb_checker.sv */
// ----------------------------------------------------------------------------
// stsgb_checker
// port-level checks of the spike generator bank result stream
// ----------------------------------------------------------------------------
module stsgb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  a_marker_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata == 48'd0 && out_tuser == 2'd0)
    else $error("end-of-tick marker carries data");

  a_spike_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> !out_tlast)
    else $error("spike flagged as last");

  a_nonspike_is_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[1] |-> out_tlast && !out_tuser[0])
    else $error("non-spike transaction is not a marker");

endmodule

bind sensor_tuned_spike_generator_bank_unit stsgb_checker u_stsgb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

/* verif/stsgb_spike_checker.sv */
// ----------------------------------------------------------------------------
// stsgb_spike_checker
// watches the config port and both streams, predicts every spike and
// end-of-tick marker of the spike generator bank and compares them in order
// ----------------------------------------------------------------------------
module stsgb_spike_checker
  import stsgb_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [31:0]  cfg_wdata,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [119:0] in_tdata,
  input  logic [1:0]   in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [47:0]  out_tdata,
  input  logic [1:0]   out_tuser,
  input  logic         out_tlast,
  output int           fail_count,
  output int           spikes_due,
  output int           spikes_seen,
  output int           markers_seen,
  output int           sensor_updates
);

  typedef struct packed {
    logic [31:0] packet_key;
    logic [15:0] spike_id;
    logic        fabric;
    logic        is_spike;
    logic        last;
  } spike_rec_t;

  spike_rec_t spike_q[$];

  logic               has_key;
  logic [31:0]        routing_key;
  logic signed [15:0] sensor_offset;
  logic [15:0]        clamp_hi;
  logic [4:0]         samp_shift;
  logic [30:0]        lut_scale;
  logic [30:0]        period_floor;
  logic [5:0]         source_count;

  logic signed [31:0] period_tbl [TBL_DEPTH];
  logic [15:0]        src_tag    [SOURCES];
  logic signed [31:0] mean_per   [SOURCES];
  logic signed [31:0] countdown  [SOURCES];
  bit                 primed;

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fff_ffff;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic int live_sources();
    return (source_count > SOURCES) ? SOURCES : int'(source_count);
  endfunction

  task automatic report(input string what);
    $display("[%0t] spike check: %s", $realtime, what);
    fail_count++;
  endtask

  task automatic run_tick();
    spike_rec_t rec;
    logic signed [31:0] c;
    if (primed) begin
      for (int i = 0; i < live_sources(); i++) begin
        if (mean_per[i] == 0) continue;
        c = countdown[i];
        if (c <= 0) begin
          rec.packet_key = has_key ? (routing_key | {16'd0, src_tag[i]}) : 32'd0;
          rec.spike_id   = src_tag[i];
          rec.fabric     = has_key;
          rec.is_spike   = 1'b1;
          rec.last       = 1'b0;
          spike_q.push_back(rec);
          c = clamp32(longint'(c) + longint'(mean_per[i]));
        end
        countdown[i] = clamp32(longint'(c) - longint'(ONE_FIX));
      end
    end
    primed = 1'b1;
    rec = '0;
    rec.last = 1'b1;
    spike_q.push_back(rec);
  endtask

  task automatic run_sensor(input logic [31:0] sample);
    logic signed [31:0] shifted;
    logic signed [31:0] fresh;
    logic signed [31:0] ratio;
    longint sval, rng, sum, idx, num;
    shifted = sample >> samp_shift;
    sval = shifted;
    sval = sval - sensor_offset;
    rng = clamp_hi;
    if (sval > rng) sval = rng;
    sum = sval * longint'({33'd0, lut_scale}) + (longint'(1) << (FRAC_BITS - 1));
    if (sum < 0) fresh = {1'b0, period_floor};
    else begin
      idx = sum / longint'(ONE_FIX);
      fresh = (idx >= TBL_DEPTH) ? {1'b0, period_floor} : period_tbl[idx];
    end
    for (int i = 0; i < live_sources(); i++) begin
      if (mean_per[i] != 0) begin
        num = longint'(countdown[i]) * longint'(ONE_FIX);
        ratio = clamp32(num / longint'(mean_per[i]));
        // arithmetic shift floors toward minus infinity
        num = (longint'(ratio) * longint'(fresh)) >>> FRAC_BITS;
        if (clamp32(num) > 0) countdown[i] = clamp32(num);
      end
      mean_per[i] = fresh;
    end
    sensor_updates++;
  endtask

  always @(posedge clk) begin
    spike_rec_t got, want;
    logic [8:0] slot;
    if (!rst_n) begin
      has_key       = 1'b0;
      routing_key   = '0;
      sensor_offset = -16'sd256;
      clamp_hi      = 16'd1700;
      samp_shift    = '0;
      lut_scale     = 31'd9865;
      period_floor  = '0;
      source_count  = '0;
      primed        = 1'b0;
      spike_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got = {out_tdata[31:0], out_tdata[47:32], out_tuser[0], out_tuser[1], out_tlast};
        if (spike_q.size() == 0) report($sformatf("unexpected output %h", got));
        else begin
          want = spike_q.pop_front();
          if (got.packet_key !== want.packet_key)
            report($sformatf("packet_key %h, want %h", got.packet_key, want.packet_key));
          if (got.spike_id !== want.spike_id)
            report($sformatf("spike_id %h, want %h", got.spike_id, want.spike_id));
          if (got.fabric !== want.fabric)
            report($sformatf("sent_to_fabric %b, want %b", got.fabric, want.fabric));
          if (got.is_spike !== want.is_spike)
            report($sformatf("is_spike %b, want %b", got.is_spike, want.is_spike));
          if (got.last !== want.last)
            report($sformatf("last %b, want %b", got.last, want.last));
          if (want.is_spike) spikes_seen++;
          else markers_seen++;
        end
      end
      if (cfg_we) begin
        case (cfg_addr)
          REG_HAS_KEY:      has_key       = cfg_wdata[0];
          REG_ROUTING_KEY:  routing_key   = cfg_wdata;
          REG_SENSOR_OFF:   sensor_offset = cfg_wdata[15:0];
          REG_SENSOR_RANGE: clamp_hi      = cfg_wdata[15:0];
          REG_INPUT_SHIFT:  samp_shift    = cfg_wdata[4:0];
          REG_LUT_SCALE:    lut_scale     = cfg_wdata[30:0];
          REG_PERIOD_FLOOR: period_floor  = cfg_wdata[30:0];
          REG_SOURCE_COUNT: source_count  = cfg_wdata[5:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        slot = in_tdata[40:32];
        case (in_tuser)
          KIND_TICK:   run_tick();
          KIND_SENSOR: run_sensor(in_tdata[31:0]);
          KIND_TABLE:  period_tbl[slot] = {1'b0, in_tdata[71:41]};
          KIND_SOURCE: begin
            if (slot < SOURCES) begin
              src_tag[slot]   = in_tdata[119:104];
              mean_per[slot]  = {1'b0, in_tdata[71:41]};
              countdown[slot] = in_tdata[103:72];
            end
          end
          default: ;
        endcase
      end
    end
    spikes_due <= spike_q.size();
  end

  initial begin
    fail_count     = 0;
    spikes_seen    = 0;
    markers_seen   = 0;
    sensor_updates = 0;
    spikes_due     = 0;
  end

endmodule

/* verif/sensor_tuned_spike_generator_bank_unit_test.sv */
// ----------------------------------------------------------------------------
// sensor_tuned_spike_generator_bank_unit_test
// drives loads, ticks and sensor samples under several register settings with
// random stalls on both streams; the checker predicts and compares results
// ----------------------------------------------------------------------------
module sensor_tuned_spike_generator_bank_unit_test;
  import stsgb_pkg::*;

  localparam int SETTLE_CYCLES = 2000;
  localparam int STALL_LIMIT   = 20000;
  localparam int HOLD_CYCLES   = 400;
  // low table entries loaded up front; the sensor settings keep the index below this
  localparam int TBL_FILL      = 128;
  localparam int PHASE_ITEMS   = 34;

  logic         clk;
  logic         rst_n;
  logic         cfg_we;
  logic [2:0]   cfg_addr;
  logic [31:0]  cfg_wdata;
  logic         in_tvalid;
  logic         in_tready;
  logic [119:0] in_tdata;
  logic [1:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [47:0]  out_tdata;
  logic [1:0]   out_tuser;
  logic         out_tlast;

  int fail_count, spikes_due, spikes_seen, markers_seen, sensor_updates;
  int hold_req, hold_served, idle_cycles, items_sent;
  bit quiet;

  sensor_tuned_spike_generator_bank_unit dut (.*);

  stsgb_spike_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 75) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(15, 60);
  endfunction

  function automatic logic [30:0] pick_period();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 75) return 31'($urandom_range(1, 8) << FRAC_BITS) + 31'($urandom_range(0, 32767));
    return 31'($urandom);
  endfunction

  function automatic logic [31:0] pick_countdown();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return 32'($signed($urandom_range(0, 6 << FRAC_BITS)) - (2 << FRAC_BITS));
  endfunction

  task automatic send_item(input logic [1:0] kind, input logic [31:0] sample,
                           input logic [8:0] slot, input logic [30:0] period,
                           input logic [31:0] cd, input logic [15:0] sid);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {sid, cd, period, slot, sample};
    forever begin
      @(negedge clk);
      if (in_tready) break;
    end
    @(posedge clk);
    items_sent++;
  endtask

  task automatic send_tick();
    send_item(KIND_TICK, $urandom, 9'($urandom), 31'($urandom), $urandom, 16'($urandom));
  endtask

  task automatic send_sensor(input logic [31:0] sample);
    send_item(KIND_SENSOR, sample, 9'($urandom), 31'($urandom), $urandom, 16'($urandom));
  endtask

  // sender stops until every expected transaction has drained
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (spikes_due != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(input logic [31:0] vals [8]);
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= 3'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) send_tick();
    else if (r < 70)
      send_sensor(($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 2000)) : $urandom);
    else if (r < 85)
      send_item(KIND_SOURCE, $urandom, 9'($urandom_range(0, 40)), pick_period(),
                pick_countdown(), 16'($urandom));
    else
      send_item(KIND_TABLE, $urandom, 9'($urandom), pick_period(), $urandom,
                16'($urandom));
  endtask

  // receiver side: random back-pressure plus one long hold-off on request
  initial begin
    int stall_left;
    out_tready <= 1'b0;
    stall_left = 0;
    hold_served = 0;
    @(posedge clk);
    forever begin
      if (hold_req != hold_served) begin
        hold_served = hold_req;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
        @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        stall_left = pick_gap();
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else if (spikes_due != 0 || in_tvalid) idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    logic [31:0] regs [8];
    hold_req    = 0;
    quiet       = 1'b0;
    items_sent  = 0;
    idle_cycles = 0;
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_addr  <= '0;
    cfg_wdata <= '0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= KIND_TICK;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // first tick only primes the bank, second has no active sources
    send_tick();
    send_tick();

    // preload the table entries the sensor settings can reach and every source
    for (int i = 0; i < TBL_FILL; i++)
      send_item(KIND_TABLE, '0, 9'(i),
                (i == 0) ? 31'd0 : (i == TBL_FILL - 1) ? 31'h7fff_ffff : pick_period(),
                '0, '0);
    for (int i = 0; i < SOURCES; i++) begin
      case (i)
        0: send_item(KIND_SOURCE, '0, 9'(i), 31'd0, 32'sd0, 16'h0000);
        1: send_item(KIND_SOURCE, '0, 9'(i), 31'h7fff_ffff, 32'h7fff_ffff, 16'hffff);
        2: send_item(KIND_SOURCE, '0, 9'(i), 31'h7fff_ffff, 32'h8000_0000, 16'h1234);
        3: send_item(KIND_SOURCE, '0, 9'(i), 31'd1 << FRAC_BITS, 32'h8000_0000, 16'h0001);
        default: send_item(KIND_SOURCE, '0, 9'(i), pick_period(), pick_countdown(),
                           16'($urandom));
      endcase
    end
    // source slots beyond the bank are ignored
    send_item(KIND_SOURCE, '0, 9'd32, 31'd1 << FRAC_BITS, 32'sd0, 16'hdead);
    send_item(KIND_SOURCE, '0, 9'd511, 31'd1 << FRAC_BITS, 32'sd0, 16'hbeef);
    settle();

    // keyed spikes, source count above the bank size
    regs = '{32'd1, 32'ha5a5_0000, 32'hffff_ff00, 32'd1700, 32'd0, 32'd2400, 32'd0, 32'd40};
    write_regs(regs);
    repeat (4) send_tick();
    send_sensor(32'h0000_0000);
    send_tick();
    send_sensor(32'hffff_ffff);
    send_tick();
    send_sensor(32'd900);
    repeat (3) send_tick();

    for (int p = 0; p < 6; p++) begin
      settle();
      if (p == 0)
        regs = '{32'd0, 32'd0, 32'hffff_8001, 32'd1, 32'd0, 32'd0, 32'd0, 32'd1};
      else if (p == 1)
        regs = '{32'd1, 32'hffff_ffff, 32'd32767, 32'd65534, 32'd31, 32'h7fff_ffff,
                 32'h7fff_ffff, 32'd63};
      else
        regs = '{32'($urandom_range(0, 1)), $urandom,
                 32'($urandom_range(0, 65534) - 32767), 32'($urandom_range(500, 4000)),
                 32'($urandom_range(0, 3)), 32'($urandom_range(200, 1000)),
                 32'(pick_period()), 32'($urandom_range(0, 40))};
      write_regs(regs);
      quiet = (p == 3);
      if (p == 2) begin
        // hold the output while ticks keep coming so the block backs up
        hold_req++;
        repeat (30) send_tick();
      end
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        random_item();
        if (p == 4 && k == 15) settle();
      end
    end

    settle();
    $display("items %0d, spikes %0d, markers %0d, sensor updates %0d",
             items_sent, spikes_seen, markers_seen, sensor_updates);
    $display("covered keyed and unkeyed spikes, saturation, rescale and register extremes");
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
